// ----- src/rtcm3_pkg.sv -----
// Shared types, constants and the CRC-24Q byte update for the RTCM3 frame receiver.
package rtcm3_pkg;

    localparam logic [7:0]  SYNC_BYTE        = 8'hD3;
    localparam logic [24:0] CRC_POLY         = 25'h1864CFB;
    localparam logic [10:0] FRAME_OVERHEAD   = 11'd6;
    localparam int          FRAME_BYTES_MAX  = 1029;
    localparam logic [10:0] MAX_LEN_RESET    = 11'd1029;

    // Codes carried on byte_class.
    localparam logic [2:0] CLASS_STREAM   = 3'd0;
    localparam logic [2:0] CLASS_FRAME    = 3'd1;
    localparam logic [2:0] CLASS_CRC_OK   = 3'd2;
    localparam logic [2:0] CLASS_CRC_BAD  = 3'd3;
    localparam logic [2:0] CLASS_TOO_LONG = 3'd4;

    // Frame parser phases.
    typedef enum logic [3:0] {
        PH_SYNC = 4'b0001,
        PH_LEN1 = 4'b0010,
        PH_LEN2 = 4'b0100,
        PH_BODY = 4'b1000
    } phase_t;

    // One byte of CRC-24Q, most significant bit first.
    function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        c = crc ^ {b, 16'h0000};
        for (int k = 0; k < 8; k++)
        begin
            if (c[23])
                c = {c[22:0], 1'b0} ^ CRC_POLY[23:0];
            else
                c = {c[22:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- src/rtcm3_frame_receiver_crc24q.sv -----
// Top level of the RTCM3 frame receiver with CRC-24Q check.
//
// This block scans a received byte stream for RTCM3 frames (sync byte 0xD3, a 10-bit
// payload length, the payload and a 24-bit CRC) and tags every byte with a class:
// stream byte, frame byte, frame end with good CRC, frame end with bad CRC, or frame
// aborted as too long at the second length byte. It takes one byte item per clock
// cycle while in_ready is high and returns exactly one result item per byte. The
// single processing stage sits between the input register, which holds the accepted
// byte, and the result register, and moves when the output side is not stalled:
// the parser state machine and a byte-wide CRC-24Q update (eight unrolled shift
// steps, zero seed) finish within the cycle and load the result register.
// A result that waits on the output stalls the processing stage; the input register
// can still take one more item, and after that in_ready stays low until the waiting
// result is taken.
// At frame end the result also carries the 12-bit message type and the total frame
// length; a saturating 16-bit counter of CRC failures is reported with every item.
// Setting resync on an item abandons any partial frame before that byte is parsed.
// The length limit is the smaller of the max_frame_len register and MAX_FRAME_BYTES;
// write the register only while no item is in flight.
module rtcm3_frame_receiver_crc24q
    import rtcm3_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = FRAME_BYTES_MAX
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [10:0] cfg_write_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        resync,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_class,
    output logic [7:0]  byte_echo,
    output logic [11:0] message_type,
    output logic [10:0] frame_length,
    output logic [15:0] crc_error_count
);

    localparam logic [10:0] LIMIT_CAP = 11'(MAX_FRAME_BYTES);

    // Configuration register.
    logic [10:0] max_frame_len_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_resync_reg;

    // Parser state.
    phase_t      phase_reg,        phase_next;
    logic [10:0] byte_index_reg,   byte_index_next;
    logic [10:0] total_length_reg, total_length_next;
    logic [23:0] running_crc_reg,  running_crc_next;
    logic [23:0] tail_bytes_reg,   tail_bytes_next;
    logic [11:0] type_capture_reg, type_capture_next;
    logic [15:0] crc_failures_reg, crc_failures_next;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  class_reg,  class_next;
    logic [7:0]  echo_reg;
    logic [11:0] mtype_reg,  mtype_next;
    logic [10:0] flen_reg,   flen_next;

    logic        stage_advance;
    logic        process;
    logic [10:0] limit;
    phase_t      phase_cur;
    logic [23:0] crc_stepped;
    logic [10:0] len_with_overhead;

    // The processing stage moves whenever the result register is free or being emptied.
    assign stage_advance = !out_valid_reg || out_ready;
    assign process       = in_valid_reg && stage_advance;
    assign in_ready      = !in_valid_reg || stage_advance;

    assign limit             = (max_frame_len_reg > LIMIT_CAP) ? LIMIT_CAP : max_frame_len_reg;
    assign phase_cur         = in_resync_reg ? PH_SYNC : phase_reg;
    assign crc_stepped       = crc24q_byte(running_crc_reg, in_byte_reg);
    assign len_with_overhead = (total_length_reg | {3'b000, in_byte_reg}) + FRAME_OVERHEAD;

    always_comb
    begin
        phase_next        = phase_cur;
        byte_index_next   = byte_index_reg;
        total_length_next = total_length_reg;
        running_crc_next  = running_crc_reg;
        tail_bytes_next   = tail_bytes_reg;
        type_capture_next = type_capture_reg;
        crc_failures_next = crc_failures_reg;
        class_next        = CLASS_STREAM;
        mtype_next        = 12'h000;
        flen_next         = 11'd0;

        case (phase_cur)
            PH_SYNC:
            begin
                if (in_byte_reg == SYNC_BYTE)
                begin
                    running_crc_next  = crc24q_byte(24'h000000, in_byte_reg);
                    byte_index_next   = 11'd1;
                    tail_bytes_next   = 24'h000000;
                    type_capture_next = 12'h000;
                    phase_next        = PH_LEN1;
                    class_next        = CLASS_FRAME;
                end
            end
            PH_LEN1:
            begin
                running_crc_next  = crc_stepped;
                total_length_next = {1'b0, in_byte_reg[1:0], 8'h00};
                byte_index_next   = 11'd2;
                phase_next        = PH_LEN2;
                class_next        = CLASS_FRAME;
            end
            PH_LEN2:
            begin
                running_crc_next  = crc_stepped;
                total_length_next = len_with_overhead;
                byte_index_next   = 11'd3;
                if (len_with_overhead <= limit)
                begin
                    phase_next = PH_BODY;
                    class_next = CLASS_FRAME;
                end
                else
                begin
                    phase_next = PH_SYNC;
                    class_next = CLASS_TOO_LONG;
                    flen_next  = len_with_overhead;
                end
            end
            PH_BODY:
            begin
                if (byte_index_reg == 11'd3)
                    type_capture_next = {in_byte_reg, 4'h0};
                else if (byte_index_reg == 11'd4)
                    type_capture_next = {type_capture_reg[11:4], in_byte_reg[7:4]};

                // The last three bytes are the CRC; they go to the tail register.
                if (({1'b0, byte_index_reg} + 12'd3) < {1'b0, total_length_reg})
                    running_crc_next = crc_stepped;
                else
                    tail_bytes_next = {tail_bytes_reg[15:0], in_byte_reg};

                byte_index_next = byte_index_reg + 11'd1;
                class_next      = CLASS_FRAME;

                if (byte_index_next >= total_length_reg)
                begin
                    if (running_crc_next == tail_bytes_next)
                        class_next = CLASS_CRC_OK;
                    else
                    begin
                        class_next = CLASS_CRC_BAD;
                        if (crc_failures_reg != 16'hFFFF)
                            crc_failures_next = crc_failures_reg + 16'd1;
                    end
                    mtype_next = type_capture_next;
                    flen_next  = total_length_reg;
                    phase_next = PH_SYNC;
                end
            end
            default:
            begin
                phase_next = PH_SYNC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_len_reg <= MAX_LEN_RESET;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_SYNC;
            byte_index_reg    <= 11'd0;
            total_length_reg  <= 11'd0;
            running_crc_reg   <= 24'h000000;
            tail_bytes_reg    <= 24'h000000;
            type_capture_reg  <= 12'h000;
            crc_failures_reg  <= 16'h0000;
        end
        else
        begin
            if (cfg_write_en)
                max_frame_len_reg <= cfg_write_data;

            if (in_ready)
                in_valid_reg <= in_valid;

            if (stage_advance)
                out_valid_reg <= in_valid_reg;

            if (process)
            begin
                phase_reg        <= phase_next;
                byte_index_reg   <= byte_index_next;
                total_length_reg <= total_length_next;
                running_crc_reg  <= running_crc_next;
                tail_bytes_reg   <= tail_bytes_next;
                type_capture_reg <= type_capture_next;
                crc_failures_reg <= crc_failures_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg   <= data_byte;
            in_resync_reg <= resync;
        end
        if (process)
        begin
            class_reg <= class_next;
            echo_reg  <= in_byte_reg;
            mtype_reg <= mtype_next;
            flen_reg  <= flen_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign byte_class      = class_reg;
    assign byte_echo       = echo_reg;
    assign message_type    = mtype_reg;
    assign frame_length    = flen_reg;
    assign crc_error_count = crc_failures_reg;

endmodule

// ----- bench/rtcm3_frame_receiver_crc24q_test.sv -----
// Self-checking testbench for the RTCM3 frame receiver with CRC-24Q check.
`timescale 1ns / 1ps

module rtcm3_frame_receiver_crc24q_test;
    import rtcm3_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 7;
    // Longest stretch without any accepted item before the run is declared hung.
    // The worst legal stretch is the long output hold-off plus the drain of the
    // pipeline registers, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 120;
    localparam int PHASE_ITEMS    = 120;
    localparam int REPORT_CAP     = 40;

    // One result item as the block presents it on its output ports.
    typedef struct packed {
        logic [2:0]  cls;
        logic [7:0]  echo;
        logic [11:0] mtype;
        logic [10:0] flen;
        logic [15:0] fails;
    } byte_tag_t;

    // Scoreboard: tracks the frame parser state of the block, works out the tag
    // of every accepted byte and compares the returned tags in order.
    class frame_tag_scoreboard;
        logic [10:0] limit_reg;
        phase_t      ph;
        logic [10:0] pos;
        logic [10:0] frame_len;
        logic [23:0] crc;
        logic [23:0] tail;
        logic [11:0] type_cap;
        logic [15:0] fail_count;
        byte_tag_t   pending_tags[$];
        int          mismatches;
        int          reported;

        function new();
            limit_reg  = MAX_LEN_RESET;
            ph         = PH_SYNC;
            pos        = '0;
            frame_len  = '0;
            crc        = '0;
            tail       = '0;
            type_cap   = '0;
            fail_count = '0;
            mismatches = 0;
            reported   = 0;
        endfunction

        // Bit-serial CRC-24Q, most significant bit first.
        static function logic [23:0] crc_step(logic [23:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[23] ^ b[i];
                c  = {c[22:0], 1'b0};
                if (fb)
                    c = c ^ CRC_POLY[23:0];
            end
            return c;
        endfunction

        function void set_limit(logic [10:0] v);
            limit_reg = v;
        endfunction

        function int pending();
            return pending_tags.size();
        endfunction

        // Advance the parser by one accepted byte and queue the tag it earns.
        function void note_byte(logic [7:0] b, logic rs);
            byte_tag_t   t;
            logic [10:0] eff;
            eff     = (limit_reg > FRAME_BYTES_MAX) ? 11'(FRAME_BYTES_MAX) : limit_reg;
            t.cls   = CLASS_STREAM;
            t.echo  = b;
            t.mtype = '0;
            t.flen  = '0;
            if (rs)
                ph = PH_SYNC;
            case (ph)
                PH_SYNC:
                begin
                    if (b == SYNC_BYTE)
                    begin
                        crc      = crc_step(24'h0, b);
                        pos      = 11'd1;
                        tail     = '0;
                        type_cap = '0;
                        ph       = PH_LEN1;
                        t.cls    = CLASS_FRAME;
                    end
                end
                PH_LEN1:
                begin
                    crc       = crc_step(crc, b);
                    frame_len = {1'b0, b[1:0], 8'h00};
                    pos       = 11'd2;
                    ph        = PH_LEN2;
                    t.cls     = CLASS_FRAME;
                end
                PH_LEN2:
                begin
                    crc       = crc_step(crc, b);
                    frame_len = (frame_len | {3'b000, b}) + FRAME_OVERHEAD;
                    pos       = 11'd3;
                    if (frame_len <= eff)
                    begin
                        ph    = PH_BODY;
                        t.cls = CLASS_FRAME;
                    end
                    else
                    begin
                        ph     = PH_SYNC;
                        t.cls  = CLASS_TOO_LONG;
                        t.flen = frame_len;
                    end
                end
                default:
                begin
                    // The type comes from frame bytes 3 and 4, CRC bytes or not.
                    if (pos == 11'd3)
                        type_cap = {b, 4'h0};
                    else if (pos == 11'd4)
                        type_cap = {type_cap[11:4], b[7:4]};
                    if (int'(pos) + 3 < int'(frame_len))
                        crc = crc_step(crc, b);
                    else
                        tail = {tail[15:0], b};
                    pos   = pos + 11'd1;
                    t.cls = CLASS_FRAME;
                    if (pos >= frame_len)
                    begin
                        if (crc == tail)
                            t.cls = CLASS_CRC_OK;
                        else
                        begin
                            t.cls = CLASS_CRC_BAD;
                            if (fail_count != 16'hFFFF)
                                fail_count = fail_count + 16'd1;
                        end
                        t.mtype = type_cap;
                        t.flen  = frame_len;
                        ph      = PH_SYNC;
                    end
                end
            endcase
            t.fails = fail_count;
            pending_tags.push_back(t);
        endfunction

        function void check_result(byte_tag_t got);
            byte_tag_t want;
            if (pending_tags.size() == 0)
            begin
                mismatches++;
                if (reported++ < REPORT_CAP)
                    $display("%0t: result with no item waiting: class %0d echo %02h",
                             $time, got.cls, got.echo);
                return;
            end
            want = pending_tags.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (reported++ < REPORT_CAP)
                    $display({"%0t: expected class %0d echo %02h type %0d length %0d ",
                              "fails %0d, got class %0d echo %02h type %0d length %0d ",
                              "fails %0d"},
                             $time, want.cls, want.echo, want.mtype, want.flen, want.fails,
                             got.cls, got.echo, got.mtype, got.flen, got.fails);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write_en;
    logic [10:0] cfg_write_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        resync;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  byte_class;
    logic [7:0]  byte_echo;
    logic [11:0] message_type;
    logic [10:0] frame_length;
    logic [15:0] crc_error_count;

    frame_tag_scoreboard sb = new();

    // Knobs and counters for the sender, receiver and watchdog processes.
    bit tx_idling      = 1'b1;
    bit rx_idling      = 1'b1;
    bit long_stall_req = 1'b0;
    int sent_items     = 0;
    int cur_limit      = FRAME_BYTES_MAX;
    int quiet_cycles   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    rtcm3_frame_receiver_crc24q u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .resync          (resync),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .byte_class      (byte_class),
        .byte_echo       (byte_echo),
        .message_type    (message_type),
        .frame_length    (frame_length),
        .crc_error_count (crc_error_count)
    );

    // Watchdog: a run that accepts nothing on either side for too long is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: checks every accepted result item, then decides whether to
    // take the next one. Hold-offs come as short random bursts, plus one long
    // stretch on request that lets the block fill up and push back on its input.
    initial
    begin
        byte_tag_t got;
        int        hold;
        hold = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.cls   = byte_class;
                got.echo  = byte_echo;
                got.mtype = message_type;
                got.flen  = frame_length;
                got.fails = crc_error_count;
                sb.check_result(got);
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                hold = LONG_STALL - 1;
                out_ready <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one byte item and wait until the block takes it. An idle gap of random
    // length may come first while sender idling is on.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        if (tx_idling && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        resync    <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b, rs);
        sent_items++;
    endtask

    // Build one frame with a random payload of plen bytes and random spare
    // header bits. A corrupt frame gets one CRC bit flipped. When keep is
    // positive and short of the frame, only that many leading bytes go out.
    task automatic send_frame(input int plen, input bit corrupt, input int keep,
                              input bit rs_first);
        logic [7:0]  fb[$];
        logic [23:0] c;
        int          n;
        fb.push_back(SYNC_BYTE);
        fb.push_back({6'($urandom_range(0, 63)), 2'(plen >> 8)});
        fb.push_back(8'(plen));
        repeat (plen) fb.push_back(8'($urandom_range(0, 255)));
        c = 24'h0;
        foreach (fb[i])
            c = frame_tag_scoreboard::crc_step(c, fb[i]);
        if (corrupt)
            c = c ^ (24'h1 << $urandom_range(0, 23));
        fb.push_back(c[23:16]);
        fb.push_back(c[15:8]);
        fb.push_back(c[7:0]);
        n = (keep > 0 && keep < fb.size()) ? keep : fb.size();
        for (int i = 0; i < n; i++)
            send_byte(fb[i], (i == 0) ? rs_first : 1'b0);
    endtask

    // Payload sizes stay small for the most part. Low limits also see fully
    // random 10-bit lengths, which are cheap since they abort at the header,
    // and sizes right at and one past the limit.
    function automatic int pick_payload();
        int eff;
        int r;
        eff = (cur_limit > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : cur_limit;
        r   = $urandom_range(0, 9);
        if (r == 0 && eff < 200)
            return $urandom_range(0, 1023);
        if (r == 1 && eff >= 6 && eff <= 66)
            return eff - 6 + $urandom_range(0, 1);
        if (r == 2)
            return $urandom_range(0, 40);
        return $urandom_range(0, 8);
    endfunction

    // Stop offering items and wait until every expected result has come back.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The limit register may only change while no item is in flight.
    task automatic write_limit(input int v);
        wait_results_done();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= 11'(v);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.set_limit(11'(v));
        cur_limit = v;
        @(posedge clk);
    endtask

    // Mostly well-formed frames with random content; the rest are bad CRCs,
    // frames cut short, loose stream bytes and resync marks. After a cut the
    // next frame usually carries resync so that the parser is back in step.
    task automatic run_random_phase(input int n_items);
        int start;
        int kind;
        bit after_cut;
        bit rs;
        start     = sent_items;
        after_cut = 1'b0;
        while (sent_items - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            rs   = after_cut ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 4) == 0);
            after_cut = 1'b0;
            if (kind < 70)
                send_frame(pick_payload(), 1'b0, 0, rs);
            else if (kind < 80)
                send_frame(pick_payload(), 1'b1, 0, rs);
            else if (kind < 88)
            begin
                send_frame(pick_payload(), $urandom_range(0, 1), $urandom_range(1, 8), rs);
                after_cut = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                          : 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        int limits[7];
        limits = '{2047, 0, 6, 7, $urandom_range(8, 80), $urandom_range(6, 2047), 1029};

        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        in_valid       <= 1'b0;
        data_byte      <= '0;
        resync         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset limit: stream bytes at both extremes,
        // a resync while idle, the shortest frame (its type comes from CRC
        // bytes), a one-byte payload with a bad CRC, and a frame abandoned
        // after its first length byte by a resync on the next sync byte.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_frame(0, 1'b0, 0, 1'b0);
        send_frame(1, 1'b1, 0, 1'b0);
        send_byte(SYNC_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_frame(2, 1'b0, 0, 1'b1);

        // Random phases over a range of limits: above the hard maximum, below
        // the shortest frame (every frame too long), the shortest frame, and
        // random ones. The first phase also holds the output off for a long
        // stretch. The last two phases run with no idling on either side.
        for (int p = 0; p < 7; p++)
        begin
            tx_idling = (p < 5);
            rx_idling = (p < 5);
            write_limit(limits[p]);
            if (p == 0)
                long_stall_req = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        // A few closing frames back to back: bad CRCs, then a good one.
        send_frame(0, 1'b1, 0, 1'b0);
        send_frame(3, 1'b1, 0, 1'b0);
        send_frame(3, 1'b0, 0, 1'b0);

        wait_results_done();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
